[rtl/jdrm_pkg.sv]
`timescale 1ns / 1ps
// jdrm_pkg: shared types, codes and constants of the delta-R jet matcher.
// No dependencies.
package jdrm_pkg;

  localparam int MAX_TRUTH_DEF = 16;
  localparam int MAX_RECO_DEF  = 32;

  localparam int ETA_W  = 16;
  localparam int PHI_W  = 15;
  localparam int PT_W   = 16;
  localparam int SLOT_W = 5;
  localparam int RAD_W  = 14;
  localparam int R2_W   = 2 * RAD_W;
  localparam int DIFF_W = 17;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 3;

  localparam logic signed [DIFF_W-1:0] PI_Q     = 17'sd12868;
  localparam logic signed [DIFF_W-1:0] TWO_PI_Q = 17'sd25736;

  localparam logic [RAD_W-1:0] RADIUS_RST    = 14'd1229;
  localparam logic [PT_W-1:0]  TRUTH_FLR_RST = 16'd640;
  localparam logic [PT_W-1:0]  RECO_FLR_RST  = 16'd320;
  localparam logic [PT_W-1:0]  EVT_LOW_RST   = 16'd1920;
  localparam logic [PT_W-1:0]  EVT_HIGH_RST  = 16'd63936;

  typedef enum logic [1:0] {
    CMD_TRUTH = 2'd0,
    CMD_RECO  = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_MATCHED  = 3'd0,
    KIND_MISSED   = 3'd1,
    KIND_UNMATCH  = 3'd2,
    KIND_END      = 3'd3,
    KIND_REJECTED = 3'd4
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_RADIUS    = 3'd0,
    REG_TRUTH_FLR = 3'd1,
    REG_RECO_FLR  = 3'd2,
    REG_EVT_LOW   = 3'd3,
    REG_EVT_HIGH  = 3'd4
  } reg_idx_t;

  // truth jet travelling down the cell row with its best candidate so far
  typedef struct packed {
    logic                    vld;
    logic [PT_W-1:0]         tpt;
    logic signed [ETA_W-1:0] teta;
    logic signed [PHI_W-1:0] tphi;
    logic                    found;
    logic [R2_W-1:0]         best;
    logic [SLOT_W-1:0]       bj;
  } tok_t;

endpackage

[rtl/jdrm_if.sv]
`timescale 1ns / 1ps
// jdrm_in_if / jdrm_out_if: valid-ready channels of the jet matcher.
// Depends on jdrm_pkg.
interface jdrm_in_if;
  import jdrm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic signed [ETA_W-1:0] jet_eta;
  logic signed [PHI_W-1:0] jet_phi;
  logic [PT_W-1:0]         jet_pt;
  logic [PT_W-1:0]         jet_pt_raw;
  logic [PT_W-1:0]         lead_truth_pt;
  modport source (output valid, cmd, jet_eta, jet_phi, jet_pt, jet_pt_raw, lead_truth_pt,
                  input ready);
  modport sink (input valid, cmd, jet_eta, jet_phi, jet_pt, jet_pt_raw, lead_truth_pt,
                output ready);
endinterface

interface jdrm_out_if;
  import jdrm_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [PT_W-1:0]   truth_jet_pt;
  logic [PT_W-1:0]   reco_jet_pt;
  logic [PT_W-1:0]   reco_jet_pt_raw;
  logic [SLOT_W-1:0] reco_slot;
  logic              overflowed;
  logic              last;
  modport source (output valid, kind, truth_jet_pt, reco_jet_pt, reco_jet_pt_raw,
                  reco_slot, overflowed, last, input ready);
  modport sink (input valid, kind, truth_jet_pt, reco_jet_pt, reco_jet_pt_raw,
                reco_slot, overflowed, last, output ready);
endinterface

[rtl/jdrm_cell.sv]
`timescale 1ns / 1ps
// jdrm_cell: one reco jet slot; compares a passing truth jet against its jet.
// Depends on jdrm_pkg. Two register stages per cell.
module jdrm_cell #(
  parameter logic [jdrm_pkg::SLOT_W-1:0] SLOT = '0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             ld,
  input  logic signed [jdrm_pkg::ETA_W-1:0] ld_eta,
  input  logic signed [jdrm_pkg::PHI_W-1:0] ld_phi,
  input  logic [jdrm_pkg::PT_W-1:0]        ld_pt,
  input  logic [jdrm_pkg::PT_W-1:0]        ld_raw,
  input  logic                             act,
  input  logic [jdrm_pkg::PT_W-1:0]        floor_pt,
  input  logic [jdrm_pkg::R2_W-1:0]        r2,
  input  jdrm_pkg::tok_t                   tok_i,
  output jdrm_pkg::tok_t                   tok_o,
  output logic [jdrm_pkg::PT_W-1:0]        pt_o,
  output logic [jdrm_pkg::PT_W-1:0]        raw_o
);
  import jdrm_pkg::*;

  logic signed [ETA_W-1:0] eta_r;
  logic signed [PHI_W-1:0] phi_r;
  logic [PT_W-1:0]         pt_r;
  logic [PT_W-1:0]         raw_r;

  tok_t                     tok_a_r, tok_b_r;
  logic [31:0]              sq_eta_r;
  logic [R2_W-1:0]          sq_phi_r;

  logic signed [DIFF_W-1:0] deta, dphi0, dphi1, dphi2;
  logic signed [2*DIFF_W-1:0] pe, pp;
  logic [32:0]              d2;
  logic                     ok, hit;

  always_ff @(posedge clk) begin
    if (ld) begin
      eta_r <= ld_eta;
      phi_r <= ld_phi;
      pt_r  <= ld_pt;
      raw_r <= ld_raw;
    end
  end

  always_comb begin
    deta  = DIFF_W'(eta_r) - DIFF_W'(tok_i.teta);
    dphi0 = DIFF_W'(phi_r) - DIFF_W'(tok_i.tphi);
    dphi1 = (dphi0 > PI_Q) ? dphi0 - TWO_PI_Q : dphi0;
    dphi2 = (dphi1 < -PI_Q) ? dphi1 + TWO_PI_Q : dphi1;
    pe    = (2*DIFF_W)'(deta) * (2*DIFF_W)'(deta);
    pp    = (2*DIFF_W)'(dphi2) * (2*DIFF_W)'(dphi2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_a_r.vld <= 1'b0;
    end else if (en) begin
      tok_a_r  <= tok_i;
      sq_eta_r <= pe[31:0];
      sq_phi_r <= pp[R2_W-1:0];
    end
  end

  always_comb begin
    ok  = act && (pt_r >= floor_pt);
    d2  = {1'b0, sq_eta_r} + 33'(sq_phi_r);
    hit = tok_a_r.vld && ok && (d2 < 33'(r2)) &&
          (!tok_a_r.found || (d2 < 33'(tok_a_r.best)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_b_r.vld <= 1'b0;
    end else if (en) begin
      tok_b_r <= tok_a_r;
      if (hit) begin
        tok_b_r.found <= 1'b1;
        tok_b_r.best  <= d2[R2_W-1:0];
        tok_b_r.bj    <= SLOT;
      end
    end
  end

  assign tok_o = tok_b_r;
  assign pt_o  = pt_r;
  assign raw_o = raw_r;

endmodule

[rtl/jet_delta_r_matcher.sv]
`timescale 1ns / 1ps
// jet_delta_r_matcher: top level, sequencer, truth list and reco cell row.
// Depends on jdrm_pkg, jdrm_if and jdrm_cell.
//
// Usage: jets arrive on in_ch, one transaction per cycle while the block is
// idle and out_ch does not stall; cmd 0 loads a truth jet, cmd 1 a reco jet,
// cmd 2 starts a run. Loads give no result. A run walks the truth jets through
// a row of MAX_RECO reco cells, two register stages per cell, so each truth jet
// sees every reco jet. Results leave on out_ch: one per truth jet at or above
// its floor, then each unmatched reco jet at or above its floor, then an end
// transaction with last set. A run injects the truth jets, drains the cell row
// and sweeps the reco slots; in_ch.ready is low meanwhile. An event outside the
// leading-pt window gives one rejected transaction. Registers are to be written
// on cfg_we while the block is idle; the block itself does not enforce this.
// Reset empties both lists and restores the register defaults. When out_ch
// stalls the whole row and sequencer freeze; nothing is lost.
module jet_delta_r_matcher #(
  parameter int MAX_TRUTH = jdrm_pkg::MAX_TRUTH_DEF,
  parameter int MAX_RECO  = jdrm_pkg::MAX_RECO_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  jdrm_in_if.sink                           in_ch,
  jdrm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [jdrm_pkg::CIDX_W-1:0]       cfg_idx,
  input  logic [jdrm_pkg::CFG_W-1:0]        cfg_data
);
  import jdrm_pkg::*;

  localparam int TCNT_W  = $clog2(MAX_TRUTH + 1);
  localparam int TIDX_W  = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
  localparam int RCNT_W  = $clog2(MAX_RECO + 1);
  localparam int RIDX_W  = (MAX_RECO > 1) ? $clog2(MAX_RECO) : 1;
  localparam int DRAIN_LEN = 2 * MAX_RECO + 1;
  localparam int DCNT_W  = $clog2(DRAIN_LEN + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INJECT = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state_r;

  logic [RAD_W-1:0] radius_r;
  logic [PT_W-1:0]  truth_flr_r, reco_flr_r, evt_low_r, evt_high_r;
  logic [R2_W-1:0]  r2_r;

  logic signed [ETA_W-1:0] t_eta_r [MAX_TRUTH];
  logic signed [PHI_W-1:0] t_phi_r [MAX_TRUTH];
  logic [PT_W-1:0]         t_pt_r  [MAX_TRUTH];
  logic [TCNT_W-1:0]       truth_count_r, ti_r;
  logic [RCNT_W-1:0]       reco_count_r, rj_r;
  logic [MAX_RECO-1:0]     marks_r;
  logic                    ovf_r;
  logic [DCNT_W-1:0]       dcnt_r;

  logic                    out_vld_r;
  kind_t                   kind_r;
  logic [PT_W-1:0]         o_tpt_r, o_rpt_r, o_raw_r;
  logic [SLOT_W-1:0]       o_slot_r;
  logic                    o_last_r;

  logic en, acc, is_run, reject, out_set;
  tok_t tok [MAX_RECO+1];
  tok_t tok_end;
  logic [PT_W-1:0] c_pt [MAX_RECO];
  logic [PT_W-1:0] c_raw [MAX_RECO];
  logic [RIDX_W-1:0] bj_idx, rj_idx;

  assign en     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && en;
  assign acc    = in_ch.valid && in_ch.ready;
  assign is_run = acc && (in_ch.cmd == CMD_RUN);
  assign reject = (in_ch.lead_truth_pt < evt_low_r) || (in_ch.lead_truth_pt > evt_high_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RADIUS_RST;
      truth_flr_r <= TRUTH_FLR_RST;
      reco_flr_r  <= RECO_FLR_RST;
      evt_low_r   <= EVT_LOW_RST;
      evt_high_r  <= EVT_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RADIUS:    radius_r    <= cfg_data[RAD_W-1:0];
        REG_TRUTH_FLR: truth_flr_r <= cfg_data;
        REG_RECO_FLR:  reco_flr_r  <= cfg_data;
        REG_EVT_LOW:   evt_low_r   <= cfg_data;
        REG_EVT_HIGH:  evt_high_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= R2_W'(radius_r) * R2_W'(radius_r);
  end

  // truth list
  always_ff @(posedge clk) begin
    if (acc && (in_ch.cmd == CMD_TRUTH) && (truth_count_r < TCNT_W'(MAX_TRUTH))) begin
      t_eta_r[truth_count_r[TIDX_W-1:0]] <= in_ch.jet_eta;
      t_phi_r[truth_count_r[TIDX_W-1:0]] <= in_ch.jet_phi;
      t_pt_r[truth_count_r[TIDX_W-1:0]]  <= in_ch.jet_pt;
    end
  end

  // truth jet injection into the row
  always_comb begin
    tok[0]       = '0;
    if ((state_r == S_INJECT) && en && (ti_r < truth_count_r)) begin
      tok[0].vld  = t_pt_r[ti_r[TIDX_W-1:0]] >= truth_flr_r;
      tok[0].tpt  = t_pt_r[ti_r[TIDX_W-1:0]];
      tok[0].teta = t_eta_r[ti_r[TIDX_W-1:0]];
      tok[0].tphi = t_phi_r[ti_r[TIDX_W-1:0]];
    end
  end

  for (genvar g = 0; g < MAX_RECO; g++) begin : g_cell
    jdrm_cell #(.SLOT(SLOT_W'(g))) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .ld       (acc && (in_ch.cmd == CMD_RECO) && (reco_count_r == RCNT_W'(g))),
      .ld_eta   (in_ch.jet_eta),
      .ld_phi   (in_ch.jet_phi),
      .ld_pt    (in_ch.jet_pt),
      .ld_raw   (in_ch.jet_pt_raw),
      .act      (RCNT_W'(g) < reco_count_r),
      .floor_pt (reco_flr_r),
      .r2       (r2_r),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .pt_o     (c_pt[g]),
      .raw_o    (c_raw[g])
    );
  end

  assign tok_end = tok[MAX_RECO];
  assign bj_idx  = tok_end.bj[RIDX_W-1:0];
  assign rj_idx  = rj_r[RIDX_W-1:0];

  // a result transaction is loaded into the output register this cycle
  always_comb begin
    out_set = en && tok_end.vld;
    case (state_r)
      S_IDLE: begin
        if (is_run && reject) out_set = 1'b1;
      end
      S_SWEEP: begin
        if (en && (rj_r != reco_count_r) && !marks_r[rj_idx] &&
            (c_pt[rj_idx] >= reco_flr_r)) out_set = 1'b1;
      end
      S_FIN: begin
        if (en) out_set = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      truth_count_r <= '0;
      reco_count_r  <= '0;
      marks_r       <= '0;
      ovf_r         <= 1'b0;
      ti_r          <= '0;
      rj_r          <= '0;
      dcnt_r        <= '0;
      out_vld_r     <= 1'b0;
    end else begin
      if (out_set) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;

      if (acc && (in_ch.cmd == CMD_TRUTH)) begin
        if (truth_count_r < TCNT_W'(MAX_TRUTH)) truth_count_r <= truth_count_r + TCNT_W'(1);
        else ovf_r <= 1'b1;
      end
      if (acc && (in_ch.cmd == CMD_RECO)) begin
        if (reco_count_r < RCNT_W'(MAX_RECO)) reco_count_r <= reco_count_r + RCNT_W'(1);
        else ovf_r <= 1'b1;
      end

      // results leaving the row
      if (en && tok_end.vld) begin
        o_tpt_r   <= tok_end.tpt;
        o_last_r  <= 1'b0;
        if (tok_end.found) begin
          kind_r            <= KIND_MATCHED;
          o_rpt_r           <= c_pt[bj_idx];
          o_raw_r           <= c_raw[bj_idx];
          o_slot_r          <= tok_end.bj;
          marks_r[bj_idx]   <= 1'b1;
        end else begin
          kind_r   <= KIND_MISSED;
          o_rpt_r  <= '0;
          o_raw_r  <= '0;
          o_slot_r <= '0;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (is_run) begin
            if (reject) begin
              kind_r        <= KIND_REJECTED;
              o_tpt_r       <= '0;
              o_rpt_r       <= '0;
              o_raw_r       <= '0;
              o_slot_r      <= '0;
              o_last_r      <= 1'b1;
              truth_count_r <= '0;
              reco_count_r  <= '0;
              marks_r       <= '0;
              ovf_r         <= 1'b0;
            end else begin
              state_r <= S_INJECT;
              ti_r    <= '0;
            end
          end
        end
        S_INJECT: begin
          if (en) begin
            if (ti_r < truth_count_r) begin
              ti_r <= ti_r + TCNT_W'(1);
            end else begin
              state_r <= S_DRAIN;
              dcnt_r  <= '0;
            end
          end
        end
        S_DRAIN: begin
          if (en) begin
            if (dcnt_r == DCNT_W'(DRAIN_LEN)) begin
              state_r <= S_SWEEP;
              rj_r    <= '0;
            end else begin
              dcnt_r <= dcnt_r + DCNT_W'(1);
            end
          end
        end
        S_SWEEP: begin
          if (en) begin
            if (rj_r == reco_count_r) begin
              state_r <= S_FIN;
            end else begin
              rj_r <= rj_r + RCNT_W'(1);
              if (!marks_r[rj_idx] && (c_pt[rj_idx] >= reco_flr_r)) begin
                kind_r    <= KIND_UNMATCH;
                o_tpt_r   <= '0;
                o_rpt_r   <= c_pt[rj_idx];
                o_raw_r   <= c_raw[rj_idx];
                o_slot_r  <= SLOT_W'(rj_r);
                o_last_r  <= 1'b0;
              end
            end
          end
        end
        S_FIN: begin
          if (en) begin
            kind_r        <= KIND_END;
            o_tpt_r       <= '0;
            o_rpt_r       <= '0;
            o_raw_r       <= '0;
            o_slot_r      <= '0;
            o_last_r      <= 1'b1;
            truth_count_r <= '0;
            reco_count_r  <= '0;
            marks_r       <= '0;
            ovf_r         <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // the flag is only cleared after the last result of a run is loaded, so it is
  // stable for every result of that run
  logic ovf_out_r;
  always_ff @(posedge clk) begin
    if (en) ovf_out_r <= ovf_r;
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.kind            = kind_r;
  assign out_ch.truth_jet_pt    = o_tpt_r;
  assign out_ch.reco_jet_pt     = o_rpt_r;
  assign out_ch.reco_jet_pt_raw = o_raw_r;
  assign out_ch.reco_slot       = o_slot_r;
  assign out_ch.overflowed      = ovf_out_r;
  assign out_ch.last            = o_last_r;

endmodule
